/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the sequencer RTL (pat_seq).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PAT_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define PAT_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) else $error(msg);

`endif

/* hw/rtl/pat_pkg.sv */
package pat_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // Command codes
  localparam logic [1:0] CMD_TRACK = 2'd0;
  localparam logic [1:0] CMD_RESP  = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;

  // Status codes
  localparam logic [1:0] ST_ACKED   = 2'd0;
  localparam logic [1:0] ST_NACKED  = 2'd1;
  localparam logic [1:0] ST_RELAYED = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLACK     = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_BROADCAST = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] SLACK_RESET     = 16'd2000;
  localparam logic [15:0] WINDOW_RESET    = 16'd5000;
  localparam logic [31:0] BROADCAST_RESET = 32'hFFFF_FFFF;

  // What one walk over the table is doing
  typedef enum logic [1:0] {
    WM_DROP,
    WM_RESP,
    WM_SWEEP
  } walk_mode_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] node;
    logic [31:0] deadline;
    logic        relayed;
  } entry_t;

  typedef struct packed {
    logic [15:0] slack;
    logic [15:0] window;
    logic [31:0] broadcast;
  } cfg_t;

  // Verdict of the compare unit on one entry
  typedef struct packed {
    logic        remove;
    logic        emit;
    logic        stop;
    logic [1:0]  status;
    entry_t      entry_out;
    logic [31:0] deadline;
  } eval_t;

endpackage

/* hw/rtl/pending_ack_timeout_table.sv */
// Channel   Handshake                 Payload
// command   start & !busy             command, message_id, node, window_ms, is_ack, now_ms
// config    cfg_valid & cfg_ready     cfg_index, cfg_data
// result    result_valid (1 cycle)    status_id, status, last
//
// Track: append; into a full table, a compaction walk drops the oldest entry first.
// Response and sweep: a walk, one entry per cycle through the table port.
// Commands that do nothing leave busy low. Results are registered from the walk.
// Reset (rst, synchronous) empties the table and loads the register defaults.
// Results cannot stall: the receiver must take each beat in the cycle it is shown.
module pending_ack_timeout_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] message_id,
  input  logic [31:0] node,
  input  logic [15:0] window_ms,
  input  logic        is_ack,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [31:0] status_id,
  output logic [1:0]  status,
  output logic        last
);

  pat_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slack     <= pat_pkg::SLACK_RESET;
      cfg.window    <= pat_pkg::WINDOW_RESET;
      cfg.broadcast <= pat_pkg::BROADCAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pat_pkg::CFG_SLACK:     cfg.slack     <= cfg_data[15:0];
        pat_pkg::CFG_WINDOW:    cfg.window    <= cfg_data[15:0];
        pat_pkg::CFG_BROADCAST: cfg.broadcast <= cfg_data;
        default: begin
          cfg.slack <= cfg.slack;
        end
      endcase
    end
  end

  pat_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start && !busy),
    .command      (command),
    .message_id   (message_id),
    .node         (node),
    .window_ms    (window_ms),
    .is_ack       (is_ack),
    .now_ms       (now_ms),
    .cfg          (cfg),
    .busy         (busy),
    .result_valid (result_valid),
    .status_id    (status_id),
    .status       (status),
    .last         (last)
  );

endmodule

/* hw/rtl/pat_eval.sv */
// Shared compare unit: judges one table entry per cycle for the walk,
// and forms the deadline of a new entry.
module pat_eval (
  input  pat_pkg::walk_mode_t mode,
  input  logic                active,
  input  logic                is_first,
  input  pat_pkg::entry_t     entry,
  input  logic [31:0]         req_id,
  input  logic [31:0]         req_node,
  input  logic                req_ack,
  input  logic [31:0]         now,
  input  logic [16:0]         wsum,
  input  logic [31:0]         broadcast,
  output pat_pkg::eval_t      ev
);

  logic [31:0] age;
  logic        expired;
  logic        id_hit;
  logic        dest_ok;

  // Wrap-safe deadline test: passed when now - deadline is below 2^31
  assign age     = now - entry.deadline;
  assign expired = ~age[31];
  assign id_hit  = (entry.id == req_id);
  assign dest_ok = (entry.node == broadcast) || (req_node == entry.node);

  always_comb begin
    ev           = '0;
    ev.entry_out = entry;
    ev.deadline  = now + {15'd0, wsum};
    case (mode)
      pat_pkg::WM_DROP: begin
        ev.remove = active && is_first;
        ev.stop   = ev.remove;
      end
      pat_pkg::WM_RESP: begin
        if (active && id_hit) begin
          ev.emit = 1'b1;
          ev.stop = 1'b1;
          if (!req_ack) begin
            ev.remove = 1'b1;
            ev.status = pat_pkg::ST_NACKED;
          end else if (dest_ok) begin
            ev.remove = 1'b1;
            ev.status = pat_pkg::ST_ACKED;
          end else begin
            ev.status            = pat_pkg::ST_RELAYED;
            ev.entry_out.relayed = 1'b1;
          end
        end
      end
      pat_pkg::WM_SWEEP: begin
        if (active && expired) begin
          ev.remove = 1'b1;
          ev.emit   = ~entry.relayed;
          ev.status = pat_pkg::ST_TIMEOUT;
        end
      end
      default: begin
        ev.remove = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/pat_seq.sv */
`include "assert_macros.svh"

// Table store and walk sequencer. A walk reads one entry per cycle and
// writes kept entries back at a trailing pointer, which compacts the table.
module pat_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          command,
  input  logic [31:0]         message_id,
  input  logic [31:0]         node,
  input  logic [15:0]         window_ms,
  input  logic                is_ack,
  input  logic [31:0]         now_ms,
  input  pat_pkg::cfg_t       cfg,
  output logic                busy,
  output logic                result_valid,
  output logic [31:0]         status_id,
  output logic [1:0]          status,
  output logic                last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPEND
  } state_t;

  state_t                     state;
  pat_pkg::walk_mode_t        mode;
  logic [31:0]                id_r;
  logic [31:0]                node_r;
  logic                       ack_r;
  logic [31:0]                now_r;
  logic [16:0]                wsum_r;
  logic [pat_pkg::CNT_W-1:0]  count;
  logic [pat_pkg::CNT_W-1:0]  rd_ptr;
  logic [pat_pkg::CNT_W-1:0]  wr_ptr;
  logic [pat_pkg::CNT_W-1:0]  e_idx;
  logic                       rvalid;
  logic                       stop;
  logic [pat_pkg::RES_W-1:0]  nres;
  logic                       hold_valid;
  logic [31:0]                hold_id;
  logic [1:0]                 hold_status;

  pat_pkg::entry_t            mem [pat_pkg::TABLE_DEPTH];
  pat_pkg::entry_t            rdata;
  pat_pkg::entry_t            wdata;
  logic                       mem_re;
  logic                       mem_we;
  logic [pat_pkg::IDX_W-1:0]  waddr;
  logic                       walk_end;
  logic [15:0]                win_sel;
  pat_pkg::eval_t             ev;

  assign busy    = (state != S_IDLE);
  assign win_sel = (window_ms == 16'd0) ? cfg.window : window_ms;

  pat_eval u_eval (
    .mode      (mode),
    .active    (~stop),
    .is_first  (e_idx == '0),
    .entry     (rdata),
    .req_id    (id_r),
    .req_node  (node_r),
    .req_ack   (ack_r),
    .now       (now_r),
    .wsum      (wsum_r),
    .broadcast (cfg.broadcast),
    .ev        (ev)
  );

  // Memory port control
  always_comb begin
    mem_re   = (state == S_WALK) && (rd_ptr < count);
    walk_end = (state == S_WALK) && !mem_re && !rvalid;
    mem_we   = 1'b0;
    waddr    = wr_ptr[pat_pkg::IDX_W-1:0];
    wdata    = ev.entry_out;
    if (state == S_WALK) begin
      mem_we = rvalid && !ev.remove;
    end else if (state == S_APPEND) begin
      mem_we        = 1'b1;
      waddr         = count[pat_pkg::IDX_W-1:0];
      wdata.id      = id_r;
      wdata.node    = node_r;
      wdata.deadline = ev.deadline;
      wdata.relayed = 1'b0;
    end
  end

  // Entry store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[rd_ptr[pat_pkg::IDX_W-1:0]];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rvalid       <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      stop         <= 1'b0;
      nres         <= '0;
      mode         <= pat_pkg::WM_DROP;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            id_r       <= message_id;
            node_r     <= node;
            ack_r      <= is_ack;
            now_r      <= now_ms;
            wsum_r     <= {1'b0, win_sel} + {1'b0, cfg.slack};
            rd_ptr     <= '0;
            wr_ptr     <= '0;
            rvalid     <= 1'b0;
            stop       <= 1'b0;
            nres       <= '0;
            hold_valid <= 1'b0;
            case (command)
              pat_pkg::CMD_TRACK: begin
                if (message_id != 32'd0) begin
                  if (count == pat_pkg::CNT_W'(pat_pkg::TABLE_DEPTH)) begin
                    mode  <= pat_pkg::WM_DROP;
                    state <= S_WALK;
                  end else begin
                    state <= S_APPEND;
                  end
                end
              end
              pat_pkg::CMD_RESP: begin
                if (message_id != 32'd0 && count != '0) begin
                  mode  <= pat_pkg::WM_RESP;
                  state <= S_WALK;
                end
              end
              pat_pkg::CMD_SWEEP: begin
                if (count != '0) begin
                  mode  <= pat_pkg::WM_SWEEP;
                  state <= S_WALK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WALK: begin
          rvalid <= mem_re;
          e_idx  <= rd_ptr;
          if (mem_re) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          // judge the entry read last cycle
          if (rvalid) begin
            if (!ev.remove) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            if (ev.stop) begin
              stop <= 1'b1;
            end
            if (ev.emit) begin
              nres <= nres + 1'b1;
              if (nres == pat_pkg::RES_W'(pat_pkg::MAX_RESULTS - 1)) begin
                stop <= 1'b1;
              end
              // older held result goes out, newest is held for the last mark
              if (hold_valid) begin
                result_valid <= 1'b1;
                status_id    <= hold_id;
                status       <= hold_status;
                last         <= 1'b0;
              end
              hold_valid  <= 1'b1;
              hold_id     <= rdata.id;
              hold_status <= ev.status;
            end
          end
          if (walk_end) begin
            count <= wr_ptr;
            if (hold_valid) begin
              result_valid <= 1'b1;
              status_id    <= hold_id;
              status       <= hold_status;
              last         <= 1'b1;
              hold_valid   <= 1'b0;
            end
            state <= (mode == pat_pkg::WM_DROP) ? S_APPEND : S_IDLE;
          end
        end
        S_APPEND: begin
          count <= count + 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PAT_ASSERT(a_count_bound, clk, rst, count <= pat_pkg::CNT_W'(pat_pkg::TABLE_DEPTH), "entry count above table depth")
  `PAT_ASSERT(a_wr_behind, clk, rst, rvalid |-> (wr_ptr <= e_idx), "write pointer passed read entry")
  `PAT_ASSERT(a_append_room, clk, rst, (state == S_APPEND) |-> (count < pat_pkg::CNT_W'(pat_pkg::TABLE_DEPTH)), "append into full table")
  `PAT_ASSERT(a_last_gap, clk, rst, (result_valid && last) |=> !result_valid, "result right after last beat")

endmodule
